### hw/rtl/bucketed_distance_propagation_macros.svh
// Assertion macros for the distance propagation block.
// Used by the port checker; needs a clock named aclk and a reset named aresetn.
`ifndef BUCKETED_DISTANCE_PROPAGATION_MACROS_SVH
`define BUCKETED_DISTANCE_PROPAGATION_MACROS_SVH

// same-cycle implication, suspended during reset
`define BDP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bdp port check failed");

// next-cycle implication, suspended during reset
`define BDP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bdp port check failed");

// next-cycle implication that also holds across reset
`define BDP_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("bdp reset check failed");

`endif

### hw/rtl/bdp_pkg.sv
// Shared types and codes for the distance propagation block.
// No dependencies; imported by the engine, the top level and the checker.
package bdp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_MASK       = 2'd3;

    localparam logic [2:0] KIND_MASK  = 3'd0;
    localparam logic [2:0] KIND_SEED  = 3'd1;
    localparam logic [2:0] KIND_RUN   = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_CLEAR = 3'd4;

    localparam logic [8:0] RST_IMAGE_WIDTH    = 9'd256;
    localparam logic [8:0] RST_IMAGE_HEIGHT   = 9'd256;
    localparam logic [9:0] RST_DISTANCE_LIMIT = 10'd512;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       mask_bit;
    } in_item_t;

    typedef struct packed {
        logic       reached;
        logic [8:0] distance;
        logic [7:0] source_x;
        logic [7:0] source_y;
        logic       run_done;
    } out_item_t;

    typedef struct packed {
        logic [8:0] image_width;
        logic [8:0] image_height;
        logic [9:0] distance_limit;
        logic       use_mask;
    } cfg_t;

endpackage

### hw/rtl/bdp_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on nothing; used by bdp_engine for distances and bucket numbers.
module bdp_isqrt #(
    parameter int IN_W = 21
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [IN_W-1:0]          operand,
    output logic                     done,
    output logic [(IN_W+1)/2-1:0]    root
);
    localparam int RTW = (IN_W + 1) / 2;
    localparam int VW  = 2 * RTW;
    localparam int RMW = RTW + 2;
    localparam int NW  = $clog2(RTW + 1);

    logic [RMW-1:0] rem_reg, rem_next, rem_t, trial;
    logic [RTW-1:0] root_reg, root_next;
    logic [VW-1:0]  val_reg, val_next;
    logic [NW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;

    always_comb begin
        rem_t     = {rem_reg[RMW-3:0], val_reg[VW-1 -: 2]};
        trial     = {root_reg, 2'b01};
        rem_next  = rem_reg;
        root_next = root_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            root_next = '0;
            val_next  = VW'(operand);
            cnt_next  = NW'(RTW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_t >= trial) begin
                rem_next  = rem_t - trial;
                root_next = {root_reg[RTW-2:0], 1'b1};
            end else begin
                rem_next  = rem_t;
                root_next = {root_reg[RTW-2:0], 1'b0};
            end
            val_next = {val_reg[VW-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        root_reg <= root_next;
        val_reg  <= val_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### hw/rtl/bdp_engine.sv
// Propagation engine: pixel, pending, pool and bucket memories plus the sequencer.
// Depends on bdp_pkg and bdp_isqrt.
module bdp_engine #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int BUCKET_COUNT = 1082,
    parameter int POOL_DEPTH   = 327680
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  bdp_pkg::in_item_t  cmd,
    input  bdp_pkg::cfg_t      cfg,
    output logic               res_valid,
    input  logic               res_ready,
    output bdp_pkg::out_item_t res_data
);
    import bdp_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int PIXW = XW + YW;
    localparam int PIXN = 1 << PIXW;
    localparam int CW   = (XW > YW) ? XW : YW;
    localparam int DW   = 2 * CW + 1;
    localparam int SQW  = DW + 4;
    localparam int RTW  = (SQW + 1) / 2;
    localparam int RW   = CW + 1;
    localparam int LW   = (RW > 10) ? RW : 10;
    localparam int EW   = ((CW > 9) ? CW : 9) + 1;
    localparam int PW   = $clog2(POOL_DEPTH);
    localparam int FW   = $clog2(POOL_DEPTH + 1);
    localparam int BW   = $clog2(BUCKET_COUNT);
    localparam int LBW  = $clog2(BUCKET_COUNT + 1);
    localparam int CLRN = (PIXN > BUCKET_COUNT) ? PIXN : BUCKET_COUNT;
    localparam int CLRW = $clog2(CLRN);

    typedef struct packed {
        logic            reached;
        logic [RW-1:0]   root_d;
        logic [PIXW-1:0] src;
    } fin_t;

    typedef struct packed {
        logic          valid;
        logic [DW-1:0] sq_d;
        logic [PW-1:0] entry;
    } pend_t;

    typedef struct packed {
        logic [PIXW-1:0] pix;
        logic [PIXW-1:0] src;
        logic [DW-1:0]   sq_d;
    } pool_t;

    typedef struct packed {
        logic [PW-1:0] head;
        logic [PW-1:0] tail;
        logic [FW-1:0] count;
    } bk_t;

    typedef enum logic [13:0] {
        ST_CLR    = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_RESP   = 14'b00000000000100,
        ST_OFR_RD = 14'b00000000001000,
        ST_OFR_WR = 14'b00000000010000,
        ST_SCAN   = 14'b00000000100000,
        ST_BK     = 14'b00000001000000,
        ST_POP    = 14'b00000010000000,
        ST_CHK    = 14'b00000100000000,
        ST_SQRT   = 14'b00001000000000,
        ST_NB     = 14'b00010000000000,
        ST_NBCHK  = 14'b00100000000000,
        ST_BSQ    = 14'b01000000000000,
        ST_HOLD   = 14'b10000000000000
    } state_t;

    // memories
    logic  mask_mem [PIXN];
    fin_t  fin_mem  [PIXN];
    pend_t pend_mem [PIXN];
    pool_t pool_mem [POOL_DEPTH];
    logic [PW-1:0] link_mem [POOL_DEPTH];
    bk_t   bk_mem   [BUCKET_COUNT];

    logic            mask_we, mask_re, mask_wd, mask_rd_reg;
    logic [PIXW-1:0] mask_wa, mask_ra;
    logic            fin_we, fin_re;
    logic [PIXW-1:0] fin_wa, fin_ra;
    fin_t            fin_wd, fin_rd_reg;
    logic            pend_we, pend_re;
    logic [PIXW-1:0] pend_wa, pend_ra;
    pend_t           pend_wd, pend_rd_reg;
    logic            pool_we, pool_re;
    logic [PW-1:0]   pool_wa, pool_ra;
    pool_t           pool_wd, pool_rd_reg;
    logic            link_we;
    logic [PW-1:0]   link_wa, link_wd, link_rd_reg;
    logic            bk_we, bk_re;
    logic [BW-1:0]   bk_wa, bk_ra;
    bk_t             bk_wd, bk_rd_reg;

    always_ff @(posedge aclk) begin
        if (mask_we) mask_mem[mask_wa] <= mask_wd;
        if (mask_re) mask_rd_reg <= mask_mem[mask_ra];
    end

    always_ff @(posedge aclk) begin
        if (fin_we) fin_mem[fin_wa] <= fin_wd;
        if (fin_re) fin_rd_reg <= fin_mem[fin_ra];
    end

    always_ff @(posedge aclk) begin
        if (pend_we) pend_mem[pend_wa] <= pend_wd;
        if (pend_re) pend_rd_reg <= pend_mem[pend_ra];
    end

    always_ff @(posedge aclk) begin
        if (pool_we) pool_mem[pool_wa] <= pool_wd;
        if (pool_re) pool_rd_reg <= pool_mem[pool_ra];
    end

    always_ff @(posedge aclk) begin
        if (link_we) link_mem[link_wa] <= link_wd;
        if (pool_re) link_rd_reg <= link_mem[pool_ra];
    end

    always_ff @(posedge aclk) begin
        if (bk_we) bk_mem[bk_wa] <= bk_wd;
        if (bk_re) bk_rd_reg <= bk_mem[bk_ra];
    end

    // shared square root
    logic           sq_start, sq_done;
    logic [SQW-1:0] sq_op;
    logic [RTW-1:0] sq_root;

    bdp_isqrt #(.IN_W(SQW)) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .operand (sq_op),
        .done    (sq_done),
        .root    (sq_root)
    );

    // sequencer registers
    state_t           state_reg, state_next;
    logic [CLRW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [LBW-1:0]   low_reg, low_next;
    logic [FW-1:0]    free_reg, free_next;
    logic [PIXW-1:0]  ofr_pix_reg, ofr_pix_next, ofr_src_reg, ofr_src_next;
    logic [DW-1:0]    ofr_d_reg, ofr_d_next;
    logic [BW-1:0]    ofr_b_reg, ofr_b_next;
    logic             ofr_run_reg, ofr_run_next;
    logic [PW-1:0]    pop_e_reg, pop_e_next;
    logic [1:0]       nb_idx_reg, nb_idx_next;
    logic [PIXW-1:0]  nb_pix_reg, nb_pix_next;
    logic [DW-1:0]    nb_d_reg, nb_d_next;
    logic             rd_ok_reg, rd_ok_next;
    logic             res_run_reg, res_run_next;

    // input decode
    logic [PIXW-1:0] in_pix;
    logic            in_max, in_img;

    assign in_pix = {YW'(cmd.pos_y), XW'(cmd.pos_x)};
    assign in_max = (32'(cmd.pos_x) < MAX_WIDTH) && (32'(cmd.pos_y) < MAX_HEIGHT);
    assign in_img = in_max && (EW'(cmd.pos_x) < EW'(cfg.image_width))
                    && (EW'(cmd.pos_y) < EW'(cfg.image_height));

    // neighbor of the popped point and its squared distance to the seed
    logic [EW-1:0]   cur_x, cur_y, nx, ny, sx, sy;
    logic            nb_ok;
    logic [CW-1:0]   dx, dy;
    logic [2*CW-1:0] dx2, dy2;
    logic [PIXW-1:0] nb_pix;
    logic [DW-1:0]   nb_d;

    always_comb begin
        cur_x = EW'(pool_rd_reg.pix[XW-1:0]);
        cur_y = EW'(pool_rd_reg.pix[PIXW-1:XW]);
        sx    = EW'(pool_rd_reg.src[XW-1:0]);
        sy    = EW'(pool_rd_reg.src[PIXW-1:XW]);
        nx    = cur_x;
        ny    = cur_y;
        nb_ok = 1'b1;
        unique case (nb_idx_reg)
            2'd0: begin
                nx    = cur_x - 1'b1;
                nb_ok = (cur_x != '0);
            end
            2'd1: nx = cur_x + 1'b1;
            2'd2: begin
                ny    = cur_y - 1'b1;
                nb_ok = (cur_y != '0);
            end
            default: ny = cur_y + 1'b1;
        endcase
        nb_ok = nb_ok && (nx < EW'(cfg.image_width)) && (ny < EW'(cfg.image_height))
                && (nx < EW'(MAX_WIDTH)) && (ny < EW'(MAX_HEIGHT));
        nb_pix = {YW'(ny), XW'(nx)};
        dx     = CW'((nx > sx) ? (nx - sx) : (sx - nx));
        dy     = CW'((ny > sy) ? (ny - sy) : (sy - ny));
        dx2    = dx * dx;
        dy2    = dy * dy;
        nb_d   = DW'(dx2) + DW'(dy2);
    end

    logic          pool_full, ofr_drop;
    logic [PW-1:0] new_e;
    logic [RW-1:0] pop_r;

    assign pool_full = (free_reg == FW'(POOL_DEPTH));
    assign new_e     = free_reg[PW-1:0];
    assign ofr_drop  = (pend_rd_reg.valid && !(ofr_d_reg < pend_rd_reg.sq_d)) || pool_full;
    assign pop_r     = RW'(sq_root);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        low_next     = low_reg;
        free_next    = free_reg;
        ofr_pix_next = ofr_pix_reg;
        ofr_src_next = ofr_src_reg;
        ofr_d_next   = ofr_d_reg;
        ofr_b_next   = ofr_b_reg;
        ofr_run_next = ofr_run_reg;
        pop_e_next   = pop_e_reg;
        nb_idx_next  = nb_idx_reg;
        nb_pix_next  = nb_pix_reg;
        nb_d_next    = nb_d_reg;
        rd_ok_next   = rd_ok_reg;
        res_run_next = res_run_reg;

        mask_we = 1'b0; mask_wa = in_pix; mask_wd = cmd.mask_bit;
        mask_re = 1'b0; mask_ra = nb_pix;
        fin_we  = 1'b0; fin_wa = pool_rd_reg.pix; fin_wd = '0;
        fin_re  = 1'b0; fin_ra = nb_pix;
        pend_we = 1'b0; pend_wa = ofr_pix_reg; pend_wd = '0;
        pend_re = 1'b0; pend_ra = ofr_pix_reg;
        pool_we = 1'b0; pool_wa = new_e; pool_wd = '0;
        pool_re = 1'b0; pool_ra = bk_rd_reg.head;
        link_we = 1'b0; link_wa = bk_rd_reg.tail; link_wd = new_e;
        bk_we   = 1'b0; bk_wa = ofr_b_reg; bk_wd = '0;
        bk_re   = 1'b0; bk_ra = ofr_b_reg;
        sq_start = 1'b0;
        sq_op    = SQW'(pool_rd_reg.sq_d);

        unique case (state_reg)
            ST_CLR: begin
                if (32'(clr_cnt_reg) < PIXN) begin
                    fin_we  = 1'b1;
                    fin_wa  = clr_cnt_reg[PIXW-1:0];
                    pend_we = 1'b1;
                    pend_wa = clr_cnt_reg[PIXW-1:0];
                end
                if (32'(clr_cnt_reg) < BUCKET_COUNT) begin
                    bk_we = 1'b1;
                    bk_wa = clr_cnt_reg[BW-1:0];
                end
                if (clr_cnt_reg == CLRW'(CLRN - 1)) begin
                    low_next   = LBW'(BUCKET_COUNT);
                    free_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.kind)
                        KIND_MASK: mask_we = in_max;
                        KIND_SEED: begin
                            if (in_img) begin
                                ofr_pix_next = in_pix;
                                ofr_src_next = in_pix;
                                ofr_d_next   = '0;
                                ofr_b_next   = '0;
                                ofr_run_next = 1'b0;
                                state_next   = ST_OFR_RD;
                            end
                        end
                        KIND_RUN: state_next = ST_SCAN;
                        KIND_READ: begin
                            fin_re       = 1'b1;
                            fin_ra       = in_pix;
                            rd_ok_next   = in_img;
                            res_run_next = 1'b0;
                            state_next   = ST_RESP;
                        end
                        KIND_CLEAR: begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RESP: begin
                if (res_ready) state_next = ST_IDLE;
            end
            ST_OFR_RD: begin
                pend_re    = 1'b1;
                bk_re      = 1'b1;
                state_next = ST_OFR_WR;
            end
            ST_OFR_WR: begin
                if (!ofr_drop) begin
                    pool_we      = 1'b1;
                    pool_wd.pix  = ofr_pix_reg;
                    pool_wd.src  = ofr_src_reg;
                    pool_wd.sq_d = ofr_d_reg;
                    // chain behind the current tail
                    link_we       = (bk_rd_reg.count != '0);
                    bk_we         = 1'b1;
                    bk_wd.head    = (bk_rd_reg.count == '0) ? new_e : bk_rd_reg.head;
                    bk_wd.tail    = new_e;
                    bk_wd.count   = bk_rd_reg.count + 1'b1;
                    pend_we       = 1'b1;
                    pend_wd.valid = 1'b1;
                    pend_wd.sq_d  = ofr_d_reg;
                    pend_wd.entry = new_e;
                    free_next     = free_reg + 1'b1;
                    if (LBW'(ofr_b_reg) < low_reg) low_next = LBW'(ofr_b_reg);
                end
                if (!ofr_run_reg) begin
                    state_next = ST_IDLE;
                end else if (nb_idx_reg == 2'd3) begin
                    state_next = ST_SCAN;
                end else begin
                    nb_idx_next = nb_idx_reg + 1'b1;
                    state_next  = ST_NB;
                end
            end
            ST_SCAN: begin
                if (low_reg >= LBW'(BUCKET_COUNT)) begin
                    // all buckets drained: release the pool
                    free_next    = '0;
                    low_next     = LBW'(BUCKET_COUNT);
                    res_run_next = 1'b1;
                    state_next   = ST_RESP;
                end else begin
                    bk_re      = 1'b1;
                    bk_ra      = low_reg[BW-1:0];
                    state_next = ST_BK;
                end
            end
            ST_BK: begin
                if (bk_rd_reg.count == '0) begin
                    low_next   = low_reg + 1'b1;
                    state_next = ST_SCAN;
                end else begin
                    pool_re    = 1'b1;
                    pop_e_next = bk_rd_reg.head;
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                bk_we       = 1'b1;
                bk_wa       = low_reg[BW-1:0];
                bk_wd.head  = link_rd_reg;
                bk_wd.tail  = bk_rd_reg.tail;
                bk_wd.count = bk_rd_reg.count - 1'b1;
                pend_re     = 1'b1;
                pend_ra     = pool_rd_reg.pix;
                state_next  = ST_CHK;
            end
            ST_CHK: begin
                // skip entries superseded by a nearer offer
                if (pend_rd_reg.valid && (pend_rd_reg.entry == pop_e_reg)) begin
                    pend_we       = 1'b1;
                    pend_wa       = pool_rd_reg.pix;
                    pend_wd       = pend_rd_reg;
                    pend_wd.valid = 1'b0;
                    sq_start      = 1'b1;
                    state_next    = ST_SQRT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SQRT: begin
                if (sq_done) begin
                    fin_we         = 1'b1;
                    fin_wd.reached = 1'b1;
                    fin_wd.root_d  = pop_r;
                    fin_wd.src     = pool_rd_reg.src;
                    if (LW'(pop_r) >= LW'(cfg.distance_limit)) begin
                        state_next = ST_SCAN;
                    end else begin
                        nb_idx_next = '0;
                        state_next  = ST_NB;
                    end
                end
            end
            ST_NB: begin
                if (nb_ok) begin
                    fin_re      = 1'b1;
                    mask_re     = 1'b1;
                    nb_pix_next = nb_pix;
                    nb_d_next   = nb_d;
                    state_next  = ST_NBCHK;
                end else if (nb_idx_reg == 2'd3) begin
                    state_next = ST_SCAN;
                end else begin
                    nb_idx_next = nb_idx_reg + 1'b1;
                end
            end
            ST_NBCHK: begin
                if (fin_rd_reg.reached || (cfg.use_mask && !mask_rd_reg)) begin
                    if (nb_idx_reg == 2'd3) begin
                        state_next = ST_SCAN;
                    end else begin
                        nb_idx_next = nb_idx_reg + 1'b1;
                        state_next  = ST_NB;
                    end
                end else begin
                    sq_start   = 1'b1;
                    sq_op      = (SQW'(nb_d_reg) << 3) + SQW'(nb_d_reg);
                    state_next = ST_BSQ;
                end
            end
            ST_BSQ: begin
                if (sq_done) begin
                    if (32'(sq_root) >= BUCKET_COUNT) ofr_b_next = BW'(BUCKET_COUNT - 1);
                    else ofr_b_next = BW'(sq_root);
                    ofr_pix_next = nb_pix_reg;
                    ofr_src_next = pool_rd_reg.src;
                    ofr_d_next   = nb_d_reg;
                    ofr_run_next = 1'b1;
                    state_next   = ST_OFR_RD;
                end
            end
            ST_HOLD: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            clr_cnt_reg <= '0;
            low_reg     <= LBW'(BUCKET_COUNT);
            free_reg    <= '0;
            nb_idx_reg  <= '0;
            ofr_run_reg <= 1'b0;
            res_run_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            low_reg     <= low_next;
            free_reg    <= free_next;
            nb_idx_reg  <= nb_idx_next;
            ofr_run_reg <= ofr_run_next;
            res_run_reg <= res_run_next;
            rd_ok_reg   <= rd_ok_next;
        end
        ofr_pix_reg <= ofr_pix_next;
        ofr_src_reg <= ofr_src_next;
        ofr_d_reg   <= ofr_d_next;
        ofr_b_reg   <= ofr_b_next;
        pop_e_reg   <= pop_e_next;
        nb_pix_reg  <= nb_pix_next;
        nb_d_reg    <= nb_d_next;
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);

    always_comb begin
        res_data = '0;
        if (res_run_reg) begin
            res_data.run_done = 1'b1;
        end else if (rd_ok_reg && fin_rd_reg.reached) begin
            res_data.reached  = 1'b1;
            res_data.distance = 9'(fin_rd_reg.root_d);
            res_data.source_x = 8'(fin_rd_reg.src[XW-1:0]);
            res_data.source_y = 8'(fin_rd_reg.src[PIXW-1:XW]);
        end
    end

endmodule

### hw/rtl/bucketed_distance_propagation.sv
// Bucket-queue distance transform. A mask item is written as it is accepted; a
// seed passes through accept, pending/bucket read and write back; a read passes
// through the pixel-table read and the response state, then the output register.
// A run pops each entry through scan, bucket read, pop, check and the iterative
// square root of its distance (11 root bits at the default size), and takes each
// expanded neighbor through its checks, another square root for its bucket
// number and the offer; a single square-root unit serves both. After reset and
// after each clear item a clearing pass over every pixel and bucket entry runs
// with s_ready low; configuration writes are taken at any time.
module bucketed_distance_propagation #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int BUCKET_COUNT = 1082,
    parameter int POOL_DEPTH   = 327680
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bdp_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bdp_pkg::out_item_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bdp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bdp_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;
    logic      res_valid, res_ready;
    out_item_t res_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    cfg_next.image_width    = 9'(cfg_data);
                CFG_IMAGE_HEIGHT:   cfg_next.image_height   = 9'(cfg_data);
                CFG_DISTANCE_LIMIT: cfg_next.distance_limit = cfg_data;
                CFG_USE_MASK:       cfg_next.use_mask       = cfg_data[0];
                default: ;
            endcase
        end
    end

    // output register: take a new result whenever the slot is free or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width    <= RST_IMAGE_WIDTH;
            cfg_reg.image_height   <= RST_IMAGE_HEIGHT;
            cfg_reg.distance_limit <= RST_DISTANCE_LIMIT;
            cfg_reg.use_mask       <= 1'b0;
            m_valid_reg            <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    bdp_engine #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .BUCKET_COUNT (BUCKET_COUNT),
        .POOL_DEPTH   (POOL_DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .cmd       (s_data),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

### hw/rtl/bdp_checker.sv
// Port checker for the distance propagation block, bound to the top level.
// Depends on bdp_pkg and bucketed_distance_propagation_macros.svh.
`include "bucketed_distance_propagation_macros.svh"

module bdp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input bdp_pkg::out_item_t m_data
);
    import bdp_pkg::*;

    // a stalled result holds
    `BDP_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // the clearing pass blocks input right after reset
    `BDP_ASSERT_RST(a_clear_after_reset, !aresetn, !s_ready)

    // a run answer carries nothing else
    `BDP_ASSERT_IMP(a_run_shape, m_valid && m_data.run_done, !m_data.reached && m_data.distance == 9'd0 && m_data.source_x == 8'd0 && m_data.source_y == 8'd0)

    // an unreached read answers zero
    `BDP_ASSERT_IMP(a_unreached_zero, m_valid && !m_data.reached, m_data.distance == 9'd0 && m_data.source_x == 8'd0 && m_data.source_y == 8'd0)

endmodule

bind bucketed_distance_propagation bdp_checker u_bdp_checker (.*);
